FILE: design/swbt_pkg.sv
package swbt_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int PERIOD_WIDTH        = 16;
  localparam logic [PERIOD_WIDTH-1:0] BIT_PERIOD_RESET = 16'd1600;
  localparam int LAST_BIT            = 7;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ARM_TX = 2'd1;
  localparam logic [1:0] OP_ARM_RX = 2'd2;

  typedef logic [PERIOD_WIDTH-1:0] period_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] tx_byte;
    logic       line_in;
  } in_item_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       pullup_enable;
    logic [7:0] rx_data;
    logic       rx_done;
    logic       tx_done;
    logic       busy_res;
  } out_item_t;

  typedef enum logic [7:0] {
    MODE_IDLE     = 8'b0000_0001,
    MODE_TX_ARMED = 8'b0000_0010,
    MODE_RX_ARMED = 8'b0000_0100,
    MODE_TX_HALF  = 8'b0000_1000,
    MODE_TX_PULL  = 8'b0001_0000,
    MODE_TX_HIGH  = 8'b0010_0000,
    MODE_TX_DATA  = 8'b0100_0000,
    MODE_RX       = 8'b1000_0000
  } link_mode_t;

endpackage

FILE: design/swbt_stream_if.sv
interface swbt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/swbt_link.sv
module swbt_link
  import swbt_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  period_t   bit_period,
  output out_item_t result
);

  // wide enough for the saturated phase length 2**COUNT_WIDTH and for the period itself
  localparam int PW = (COUNT_WIDTH + 1 > PERIOD_WIDTH) ? COUNT_WIDTH + 1 : PERIOD_WIDTH;

  link_mode_t             mode, mode_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [3:0]             bit_index, bit_index_next;
  logic [7:0]             shift_reg, shift_reg_next;
  logic [7:0]             rx_hold, rx_hold_next;

  logic [PW-1:0] cap, raw_len, len, tick_inc;
  logic          use_half, phase_end;
  logic          rx_done, tx_done;

  always_comb begin
    cap      = PW'(1) << COUNT_WIDTH;
    use_half = (mode == MODE_TX_HALF) || ((mode == MODE_RX) && (bit_index == 4'd0));
    raw_len  = use_half ? PW'(bit_period >> 1) : PW'(bit_period);
    if (raw_len == '0) begin
      len = PW'(1);
    end else if (raw_len > cap) begin
      len = cap;
    end else begin
      len = raw_len;
    end
    tick_inc  = PW'(tick_count) + PW'(1);
    phase_end = (tick_inc >= len);
  end

  always_comb begin
    mode_next       = mode;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_reg_next  = shift_reg;
    rx_hold_next    = rx_hold;
    rx_done         = 1'b0;
    tx_done         = 1'b0;

    // counting phases: wrap to zero at the end, otherwise count up
    if (mode == MODE_TX_HALF || mode == MODE_TX_PULL || mode == MODE_TX_HIGH ||
        mode == MODE_TX_DATA || mode == MODE_RX) begin
      tick_count_next = phase_end ? '0 : tick_inc[COUNT_WIDTH-1:0];
    end

    case (mode)
      MODE_IDLE: begin
        if (item.operation == OP_ARM_TX) begin
          shift_reg_next = item.tx_byte;
          mode_next      = MODE_TX_ARMED;
        end else if (item.operation == OP_ARM_RX) begin
          shift_reg_next = 8'd0;
          mode_next      = MODE_RX_ARMED;
        end
      end
      MODE_TX_ARMED, MODE_RX_ARMED: begin
        if (!item.line_in) begin
          mode_next       = (mode == MODE_TX_ARMED) ? MODE_TX_HALF : MODE_RX;
          tick_count_next = '0;
          bit_index_next  = 4'd0;
        end
      end
      MODE_TX_HALF: begin
        if (phase_end) mode_next = MODE_TX_PULL;
      end
      MODE_TX_PULL: begin
        if (phase_end) mode_next = MODE_TX_HIGH;
      end
      MODE_TX_HIGH: begin
        if (phase_end) begin
          mode_next      = MODE_TX_DATA;
          bit_index_next = 4'd0;
        end
      end
      MODE_TX_DATA: begin
        if (phase_end) begin
          if (bit_index >= 4'(LAST_BIT)) begin
            bit_index_next = 4'd0;
            mode_next      = MODE_IDLE;
            tx_done        = 1'b1;
          end else begin
            bit_index_next = bit_index + 4'd1;
          end
        end
      end
      MODE_RX: begin
        // first phase is the half-bit offset, then one sample per bit
        if (phase_end) begin
          if (bit_index == 4'd0) begin
            bit_index_next = 4'd1;
          end else begin
            shift_reg_next = {shift_reg[6:0], item.line_in};
            if (bit_index >= 4'(LAST_BIT + 1)) begin
              bit_index_next = 4'd0;
              rx_hold_next   = {shift_reg[6:0], item.line_in};
              mode_next      = MODE_IDLE;
              rx_done        = 1'b1;
            end else begin
              bit_index_next = bit_index + 4'd1;
            end
          end
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  always_comb begin
    result               = '0;
    result.pullup_enable = (mode_next == MODE_TX_PULL);
    if (mode_next == MODE_TX_HIGH) begin
      result.drive_enable = 1'b1;
      result.drive_level  = 1'b1;
    end else if (mode_next == MODE_TX_DATA) begin
      result.drive_enable = 1'b1;
      result.drive_level  = shift_reg_next[3'(LAST_BIT) - bit_index_next[2:0]];
    end
    result.rx_data  = rx_hold_next;
    result.rx_done  = rx_done;
    result.tx_done  = tx_done;
    result.busy_res = (mode_next != MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      tick_count <= '0;
      bit_index  <= 4'd0;
      shift_reg  <= 8'd0;
      rx_hold    <= 8'd0;
    end else if (step) begin
      mode       <= mode_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_reg  <= shift_reg_next;
      rx_hold    <= rx_hold_next;
    end
  end

endmodule

FILE: design/single_wire_byte_transceiver_top.sv
// Half-duplex single-wire byte transceiver; the partner supplies the start bit.
// Each input item is one clock tick of the link: it carries an operation (plain
// tick, arm transmit, arm receive), the byte to send and the sampled wire level,
// and produces exactly one result item with the drive/pull-up controls, the last
// received byte, done pulses and busy. One item is accepted every cycle while the
// result side does not stall; a result passes the input register, then the link
// step logic into the result register. Output stalls back up through the input
// register. bit_period (clock ticks per bit, reset 1600) is written over the
// cfg channel, which is always ready; write it only while no item is in flight.
module single_wire_byte_transceiver_top
  import swbt_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  swbt_stream_if.sink    in_ch,
  swbt_stream_if.source  out_ch,
  swbt_stream_if.sink    cfg
);

  logic      s1_valid;
  in_item_t  s1_item;
  logic      o_valid;
  out_item_t o_item;
  out_item_t step_result;
  period_t   bit_period;
  logic      advance;

  assign advance      = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || advance;
  assign cfg.ready    = 1'b1;
  assign out_ch.valid = o_valid;
  assign out_ch.payload = o_item;

  swbt_link #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_link (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (s1_item),
    .bit_period (bit_period),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      o_valid    <= 1'b0;
      bit_period <= BIT_PERIOD_RESET;
    end else begin
      if (in_ch.ready) s1_valid <= in_ch.valid;
      if (advance) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
      if (cfg.valid) bit_period <= cfg.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) s1_item <= in_ch.payload;
    if (advance) o_item <= step_result;
  end

  // pull-up and active drive are never on together
  a_no_drive_with_pullup: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> !(o_item.drive_enable && o_item.pullup_enable))
    else $error("drive and pull-up both enabled");

  // a finished transfer leaves the link idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_item.tx_done || o_item.rx_done) |-> !o_item.busy_res)
    else $error("done pulse while still busy");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> !(o_item.tx_done && o_item.rx_done))
    else $error("tx and rx done together");

  // a held item is not dropped while the result side stalls
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("stalled item lost");

endmodule

FILE: test/single_wire_byte_transceiver_top_test.sv
`timescale 1ns / 100ps

module single_wire_byte_transceiver_top_test
  import swbt_pkg::*;
();

  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam out_item_t RES_IDLE = '0;
  localparam out_item_t RES_BUSY = '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1};

  typedef struct packed {
    logic      set_period;
    period_t   period;
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  // Reset ticks, a receive at the shortest period (armed with the wire already
  // low, an arm ignored while busy), then a transmit that the random part finishes.
  localparam dir_row_t DIRECTED [25] = '{
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b1}, 1'b1, RES_IDLE},
    '{1'b0, 16'd0, '{OP_RESERVED, 8'hFF, 1'b0}, 1'b1, RES_IDLE},
    '{1'b1, 16'd2, '{OP_ARM_RX,   8'hFF, 1'b0}, 1'b1, RES_BUSY},
    '{1'b0, 16'd0, '{OP_ARM_TX,   8'hAA, 1'b0}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b1}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b0}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b1}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_ARM_RX,   8'h0F, 1'b0}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b1}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b0}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b1}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_ARM_TX,   8'hF0, 1'b0}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b1}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b0}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b1}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_RESERVED, 8'h55, 1'b0}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b1}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b0}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b1}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b0}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b1}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_ARM_TX,   8'h00, 1'b1}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h5A, 1'b1}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_TICK,     8'h00, 1'b0}, 1'b0, RES_IDLE},
    '{1'b0, 16'd0, '{OP_ARM_RX,   8'h00, 1'b1}, 1'b0, RES_IDLE}
  };

  logic clk = 1'b0;
  logic rst;

  swbt_stream_if #(.payload_t(in_item_t))  in_ch  ();
  swbt_stream_if #(.payload_t(out_item_t)) out_ch ();
  swbt_stream_if #(.payload_t(period_t))   cfg    ();

  single_wire_byte_transceiver_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always #1 clk = ~clk;

  // link state as predicted
  link_mode_t  mode = MODE_IDLE;
  int unsigned tick_cnt = 0;
  int          bit_idx = 0;
  logic [7:0]  shreg = '0;
  logic [7:0]  rx_held = '0;
  period_t     bit_period_q = BIT_PERIOD_RESET;

  out_item_t pending_link_out[$];
  bit        idle_on = 1'b1;
  int        stall_left = 0;
  int        fail_count = 0;
  int        ticks_sent = 0;
  int        bytes_sent = 0;
  int        bytes_received = 0;
  int        periods_used = 0;

  function automatic bit phase_end(int unsigned len);
    int unsigned t;
    if (len == 0) len = 1;
    t = tick_cnt + 1;
    if (t >= len) begin
      tick_cnt = 0;
      return 1'b1;
    end
    tick_cnt = t;
    return 1'b0;
  endfunction

  function automatic out_item_t link_step(in_item_t it);
    out_item_t r;
    r = '0;
    case (mode)
      MODE_IDLE: begin
        if (it.operation == OP_ARM_TX) begin
          shreg = it.tx_byte;
          mode = MODE_TX_ARMED;
        end else if (it.operation == OP_ARM_RX) begin
          shreg = '0;
          mode = MODE_RX_ARMED;
        end
      end
      MODE_TX_ARMED, MODE_RX_ARMED: begin
        if (!it.line_in) begin
          mode = (mode == MODE_TX_ARMED) ? MODE_TX_HALF : MODE_RX;
          tick_cnt = 0;
          bit_idx = 0;
        end
      end
      MODE_TX_HALF: begin
        if (phase_end(bit_period_q >> 1)) mode = MODE_TX_PULL;
      end
      MODE_TX_PULL: begin
        if (phase_end(bit_period_q)) mode = MODE_TX_HIGH;
      end
      MODE_TX_HIGH: begin
        if (phase_end(bit_period_q)) begin
          mode = MODE_TX_DATA;
          bit_idx = 0;
        end
      end
      MODE_TX_DATA: begin
        if (phase_end(bit_period_q)) begin
          if (bit_idx >= LAST_BIT) begin
            bit_idx = 0;
            mode = MODE_IDLE;
            r.tx_done = 1'b1;
          end else begin
            bit_idx++;
          end
        end
      end
      default: begin
        // first phase of a receive is the half period, then one sample per bit
        if (phase_end(bit_idx == 0 ? bit_period_q >> 1 : bit_period_q)) begin
          if (bit_idx == 0) begin
            bit_idx = 1;
          end else begin
            shreg = {shreg[6:0], it.line_in};
            if (bit_idx >= LAST_BIT + 1) begin
              bit_idx = 0;
              rx_held = shreg;
              mode = MODE_IDLE;
              r.rx_done = 1'b1;
            end else begin
              bit_idx++;
            end
          end
        end
      end
    endcase
    r.pullup_enable = (mode == MODE_TX_PULL);
    if (mode == MODE_TX_HIGH) begin
      r.drive_enable = 1'b1;
      r.drive_level = 1'b1;
    end else if (mode == MODE_TX_DATA) begin
      r.drive_enable = 1'b1;
      r.drive_level = shreg[LAST_BIT - bit_idx];
    end
    r.rx_data = rx_held;
    r.busy_res = (mode != MODE_IDLE);
    return r;
  endfunction

  // Random tick shaped by the predicted state: mostly complete transfers.
  function automatic in_item_t next_item();
    in_item_t it;
    it.operation = OP_TICK;
    it.tx_byte = 8'($urandom_range(0, 255));
    it.line_in = 1'($urandom_range(0, 1));
    case (mode)
      MODE_IDLE: begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: it.operation = OP_ARM_TX;
          4, 5, 6, 7: it.operation = OP_ARM_RX;
          8:          it.operation = OP_TICK;
          default:    it.operation = OP_RESERVED;
        endcase
      end
      MODE_TX_ARMED, MODE_RX_ARMED: begin
        it.line_in = ($urandom_range(0, 3) != 0);
      end
      default: begin
        if ($urandom_range(0, 15) == 0) it.operation = 2'($urandom_range(0, 3));
      end
    endcase
    return it;
  endfunction

  function automatic string fmt(out_item_t v);
    return $sformatf("de=%b dl=%b pu=%b rx=%h rd=%b td=%b busy=%b", v.drive_enable,
                     v.drive_level, v.pullup_enable, v.rx_data, v.rx_done, v.tx_done,
                     v.busy_res);
  endfunction

  task automatic note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    string diff;
    if (pending_link_out.size() == 0) begin
      note_fail($sformatf("unexpected result: %s", fmt(got)));
      return;
    end
    want = pending_link_out.pop_front();
    diff = "";
    if (got.drive_enable !== want.drive_enable) diff = {diff, " drive_enable"};
    if (got.drive_level !== want.drive_level) diff = {diff, " drive_level"};
    if (got.pullup_enable !== want.pullup_enable) diff = {diff, " pullup_enable"};
    if (got.rx_data !== want.rx_data) diff = {diff, " rx_data"};
    if (got.rx_done !== want.rx_done) diff = {diff, " rx_done"};
    if (got.tx_done !== want.tx_done) diff = {diff, " tx_done"};
    if (got.busy_res !== want.busy_res) diff = {diff, " busy_res"};
    if (diff != "") begin
      note_fail($sformatf("mismatch on%s: exp %s got %s", diff, fmt(want), fmt(got)));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result(out_ch.payload);
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t r;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = link_step(it);
    pending_link_out.push_back(typed ? want : r);
    ticks_sent++;
    if (r.tx_done) bytes_sent++;
    if (r.rx_done) bytes_received++;
  endtask

  task automatic wait_link_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_link_out.size() != 0);
  endtask

  task automatic write_period(period_t p);
    wait_link_results();
    repeat (4) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.payload <= p;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
    bit_period_q = p;
    periods_used++;
  endtask

  // Writes the period if it changes, optionally arms first, then runs random
  // ticks until n_items have gone and the link is idle again.
  task automatic run_phase(period_t p, int n_items, bit idling, logic [1:0] lead_op);
    in_item_t lead;
    if (p != bit_period_q) write_period(p);
    idle_on = idling;
    if (lead_op != OP_TICK) begin
      lead.operation = lead_op;
      lead.tx_byte = 8'($urandom_range(0, 255));
      lead.line_in = 1'b1;
      send_item(lead);
    end
    for (int i = 0; i < n_items || mode != MODE_IDLE; i++) begin
      if (n_items > 0 && i == n_items / 2) wait_link_results();
      send_item(next_item());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg.valid = 1'b0;
    cfg.payload = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].set_period) write_period(DIRECTED[i].period);
      send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
    end

    run_phase(16'd2, 140, 1'b1, OP_TICK);
    run_phase(16'd3, 140, 1'b1, OP_TICK);
    run_phase(16'd7, 140, 1'b1, OP_TICK);
    run_phase(period_t'($urandom_range(2, 12)), 140, 1'b1, OP_TICK);
    // no idling at the end
    run_phase(period_t'($urandom_range(4, 16)), 100, 1'b0, OP_ARM_TX);
    // longest period: only the start of a transfer fits
    write_period(16'hFFFF);
    repeat (40) send_item(next_item());

    wait_link_results();
    repeat (8) @(posedge clk);
    $display("Ran %0d link ticks over %0d period settings, 2 up to 65535 cycles per bit.",
             ticks_sent, periods_used);
    $display("Bytes transmitted: %0d, received: %0d, failures: %0d.", bytes_sent,
             bytes_received, fail_count);
    if (fail_count == 0 && pending_link_out.size() == 0) begin
      $display("[single_wire_byte_transceiver_top] OK");
    end else begin
      $display("[single_wire_byte_transceiver_top] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[single_wire_byte_transceiver_top] ERROR");
    $finish;
  end

endmodule
